// File: design/mcc_pkg.sv
// shared types and constants for the midi 14-bit control change combiner
package mcc_pkg;

  localparam int unsigned MaxChannels = 32;
  localparam int unsigned HalfBits    = 7;
  localparam int unsigned ValueBits   = 2 * HalfBits;
  localparam logic [3:0]  CcStatus    = 4'hB;

  // pairing modes of the configuration register
  typedef enum logic [1:0] {
    ModeClear = 2'd0,
    ModeIndep = 2'd1,
    ModeWait  = 2'd2,
    ModeNone  = 2'd3
  } pair_mode_e;

  typedef struct packed {
    logic [3:0] status_nibble;
    logic [6:0] controller_number;
    logic [6:0] cc_value;
  } req_t;

  typedef struct packed {
    logic [4:0]           channel_index;
    logic [ValueBits-1:0] combined_value;
    logic                 was_msb;
  } rsp_t;

  // one memory word holds a channel's pairing state, not its valid bit
  typedef struct packed {
    logic [ValueBits-1:0] clear_val;
    logic [ValueBits-1:0] indep_val;
    logic [ValueBits-1:0] wait_val;
    logic [HalfBits-1:0]  pend_hi;
    logic                 pend_flag;
  } entry_t;

endpackage

// File: design/midi_14bit_cc_combiner.sv
// top level of the midi 14-bit control change combiner
//
// one request is taken when start_i is high and busy_o is low. a control change
// (status nibble 0xB) for controller 0-31 (msb) or 32-63 (lsb) on a channel below
// CHANNELS reads its channel entry from a single-port memory in the accept cycle,
// is updated in all three pairing modes in the following cycle (busy_o high) and
// written back; the result appears on rsp_o with done_o high in the cycle after that,
// for exactly one cycle, and cannot be stalled. any other request is dropped at
// the accept edge with no result and busy_o stays low. so a request that hits
// occupies the block for a read, then a modify-write; the next request can be
// taken in the cycle its result is shown. the memory is not cleared after reset:
// a per-channel valid bit makes an entry never written read as zero, so the block
// is ready straight out of reset. the user must write pairing_mode via cfg_we_i /
// cfg_data_i only while the block is idle; the block does not enforce it.
module midi_14bit_cc_combiner
  import mcc_pkg::*;
#(
  parameter int unsigned CHANNELS = MaxChannels
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  input  req_t       req_i,
  output logic       busy_o,
  output logic       done_o,
  output rsp_t       rsp_o,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_data_i
);

  localparam int unsigned IdxW      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam logic [5:0]  ChanLimit = 6'(CHANNELS);

  // configuration
  pair_mode_e mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ModeClear;
    end else if (cfg_we_i) begin
      mode_q <= pair_mode_e'(cfg_data_i);
    end
  end

  // request decode
  logic       accept;
  logic       hit;
  logic [4:0] req_ch;
  logic       req_msb;

  assign accept  = start_i && !busy_o;
  assign req_ch  = req_i.controller_number[4:0];
  assign req_msb = !req_i.controller_number[5];
  assign hit     = (req_i.status_nibble == CcStatus) && !req_i.controller_number[6]
                   && ({1'b0, req_ch} < ChanLimit);

  // rmw stage control: busy while the read data is being modified
  logic                busy_q;
  logic [4:0]          ch_q;
  logic                msb_q;
  logic [HalfBits-1:0] val_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else begin
      busy_q <= accept && hit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && hit) begin
      ch_q  <= req_ch;
      msb_q <= req_msb;
      val_q <= req_i.cc_value;
    end
  end

  assign busy_o = busy_q;

  // channel memory with registered read, valid bits stand in for the zero reset
  entry_t              mem [CHANNELS];
  entry_t              rd_q;
  logic                rd_vld_q;
  logic [CHANNELS-1:0] valid_q;
  logic [IdxW-1:0]     rd_idx;
  logic [IdxW-1:0]     wr_idx;
  entry_t              cur;
  entry_t              nxt;

  assign rd_idx = req_ch[IdxW-1:0];
  assign wr_idx = ch_q[IdxW-1:0];

  always_ff @(posedge clk_i) begin
    if (accept && hit) begin
      rd_q     <= mem[rd_idx];
      rd_vld_q <= valid_q[rd_idx];
    end
    if (busy_q) begin
      mem[wr_idx] <= nxt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (busy_q) begin
      valid_q[wr_idx] <= 1'b1;
    end
  end

  // busy blocks a new read until the write-back is done, so no forwarding needed
  assign cur = rd_vld_q ? rd_q : '0;

  always_comb begin
    nxt = cur;
    if (msb_q) begin
      // msb: mode 0 drops the lsb, mode 1 keeps it, mode 2 parks the msb
      nxt.clear_val = {val_q, HalfBits'(0)};
      nxt.indep_val = {val_q, cur.indep_val[HalfBits-1:0]};
      nxt.pend_hi   = val_q;
      nxt.pend_flag = 1'b1;
    end else begin
      nxt.clear_val = {cur.clear_val[ValueBits-1:HalfBits], val_q};
      nxt.indep_val = {cur.indep_val[ValueBits-1:HalfBits], val_q};
      if (cur.pend_flag) begin
        // a parked msb completes with this lsb
        nxt.wait_val  = {cur.pend_hi, val_q};
        nxt.pend_flag = 1'b0;
      end else begin
        nxt.wait_val = {cur.wait_val[ValueBits-1:HalfBits], val_q};
      end
    end
  end

  logic [ValueBits-1:0] result;

  always_comb begin
    case (mode_q)
      ModeClear: result = nxt.clear_val;
      ModeIndep: result = nxt.indep_val;
      ModeWait:  result = nxt.wait_val;
      default:   result = '0;
    endcase
  end

  // output register: one-cycle strobe, no back-pressure
  logic done_q;
  rsp_t rsp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= busy_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (busy_q) begin
      rsp_q.channel_index  <= ch_q;
      rsp_q.combined_value <= result;
      rsp_q.was_msb        <= msb_q;
    end
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  // checks
  a_done_follows_rmw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy_o))
    else $error("result without a preceding modify cycle");

  a_rmw_single_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_o |=> !busy_o)
    else $error("modify stage held for more than one cycle");

  a_drop_no_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !hit) |=> !busy_o)
    else $error("ignored request started a memory update");

  a_clear_mode_msb: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_o && msb_q && mode_q == ModeClear) |=>
      (done_o && rsp_o.combined_value[HalfBits-1:0] == '0))
    else $error("msb in clearing mode left lsb bits set");

  a_no_pending_after_lsb: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_o && !msb_q) |-> !nxt.pend_flag)
    else $error("lsb left a pending msb behind");

endmodule
